[rtl/field_strength_and_gradient_assert.svh]
// Assertion macros for the field strength and gradient block.
// Included by the checker; depends on nothing else.
`ifndef FIELD_STRENGTH_AND_GRADIENT_ASSERT_SVH
`define FIELD_STRENGTH_AND_GRADIENT_ASSERT_SVH

`define FSG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: label failed");

`define FSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: label failed");

`endif

[rtl/fsg_pkg.sv]
// Package for the field strength and gradient block.
// Holds the CORDIC angle table and the fixed-point helper constants; no dependencies.
`timescale 1ns / 1ps

package fsg_pkg;

    localparam int TRIG_FRAC    = 30;
    localparam int CORDIC_STEPS = 30;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam int NUM_REGS = 5;
    localparam logic [2:0] REG_B0  = 3'd0;
    localparam logic [2:0] REG_B1C = 3'd1;
    localparam logic [2:0] REG_B20 = 3'd2;
    localparam logic [2:0] REG_B2C = 3'd3;
    localparam logic [2:0] REG_INV = 3'd4;

    typedef logic signed [31:0] t_word;

    // One stage of the rotation chain.
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic [1:0]         quad;
        logic [30:0]        radius;
    } t_rot;

    function automatic logic signed [33:0] atan_q30(input int idx);
        logic signed [33:0] v;
        case (idx)
            0: v = 34'sd843314856;
            1: v = 34'sd497837829;
            2: v = 34'sd263043836;
            3: v = 34'sd133525158;
            4: v = 34'sd67021686;
            5: v = 34'sd33543515;
            6: v = 34'sd16775850;
            7: v = 34'sd8388437;
            8: v = 34'sd4194282;
            9: v = 34'sd2097149;
            10: v = 34'sd1048575;
            11: v = 34'sd524287;
            12: v = 34'sd262143;
            13: v = 34'sd131071;
            14: v = 34'sd65535;
            15: v = 34'sd32767;
            16: v = 34'sd16383;
            17: v = 34'sd8191;
            18: v = 34'sd4095;
            19: v = 34'sd2047;
            20: v = 34'sd1023;
            21: v = 34'sd511;
            22: v = 34'sd255;
            23: v = 34'sd127;
            24: v = 34'sd63;
            25: v = 34'sd31;
            26: v = 34'sd15;
            27: v = 34'sd8;
            28: v = 34'sd4;
            29: v = 34'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_word sat32(input logic signed [67:0] v);
        t_word r;
        if (v > 68'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -68'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/fsg_if.sv]
// Valid/ready channel interface carrying one beat of payload.
// Payload type is a parameter; no package dependency.
`timescale 1ns / 1ps

interface fsg_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/field_strength_and_gradient.sv]
// Top level of the near-axis field strength and gradient evaluator.
// Uses fsg_pkg, fsg_if, fsg_cordic_cell and fsg_qmul.
`timescale 1ns / 1ps

// One beat is accepted every cycle unless the output stalls; the result passes through the
// 30-cell CORDIC rotation chain and then the multiply and saturate stages that follow it.
// The whole pipeline advances together and holds while the output beat is not taken.
module field_strength_and_gradient #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    fsg_if.sink         s_in,
    fsg_if.source       m_out
);
    import fsg_pkg::*;

    localparam int LAT = CORDIC_STEPS + 8;

    t_word r_b0, r_b1c, r_b20, r_b2c, r_inv;
    logic [LAT-1:0] r_vld;
    logic w_en;

    assign w_en = !r_vld[LAT-1] || m_out.ready;
    assign s_in.ready = w_en;
    assign m_out.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= 32'sd16777216;
            r_b1c <= '0;
            r_b20 <= '0;
            r_b2c <= '0;
            r_inv <= 32'sd16777216;
            r_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_B0: r_b0 <= i_cfg_data;
                    REG_B1C: r_b1c <= i_cfg_data;
                    REG_B20: r_b20 <= i_cfg_data;
                    REG_B2C: r_b2c <= i_cfg_data;
                    REG_INV: r_inv <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_en) begin
                r_vld <= {r_vld[LAT-2:0], s_in.valid};
            end
        end
    end

    // Angle reduction to quadrant and radians, then the rotation chain.
    logic [ANGLE_BITS-1:0] w_ang;
    logic [ANGLE_BITS-3:0] w_rem;
    logic [ANGLE_BITS+30:0] w_zp;
    t_rot w_rot0;
    t_rot w_chain [CORDIC_STEPS+1];

    assign w_ang = s_in.data.angle[ANGLE_BITS-1:0];
    assign w_rem = w_ang[ANGLE_BITS-3:0];
    assign w_zp = (ANGLE_BITS+31)'(w_rem) * (ANGLE_BITS+31)'(HALF_PI_Q30)
        + ((ANGLE_BITS+31)'(1) << (ANGLE_BITS - 3));

    always_comb begin
        w_rot0.x = CORDIC_GAIN_Q30;
        w_rot0.y = '0;
        w_rot0.z = 34'(w_zp >> (ANGLE_BITS - 2));
        w_rot0.quad = w_ang[ANGLE_BITS-1:ANGLE_BITS-2];
        w_rot0.radius = s_in.data.radius;
    end

    assign w_chain[0] = w_rot0;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        fsg_cordic_cell #(.STEP(g)) u_cell (
            .i_clk(i_clk),
            .i_en(w_en),
            .i_rot(w_chain[g]),
            .o_rot(w_chain[g+1])
        );
    end

    // Stage A: quadrant map and rounding to FRAC_BITS.
    t_rot w_f;
    logic signed [33:0] w_c, w_s;
    logic signed [33:0] w_cr, w_sr;
    t_word r_c, r_s, r_r;
    assign w_f = w_chain[CORDIC_STEPS];

    always_comb begin
        case (w_f.quad)
            2'd0: begin w_c = w_f.x; w_s = w_f.y; end
            2'd1: begin w_c = -w_f.y; w_s = w_f.x; end
            2'd2: begin w_c = -w_f.x; w_s = -w_f.y; end
            default: begin w_c = w_f.y; w_s = -w_f.x; end
        endcase
        if (TRIG_FRAC == FRAC_BITS) begin
            w_cr = w_c;
            w_sr = w_s;
        end else begin
            w_cr = (w_c + (34'sd1 <<< (TRIG_FRAC - FRAC_BITS - 1))) >>> (TRIG_FRAC - FRAC_BITS);
            w_sr = (w_s + (34'sd1 <<< (TRIG_FRAC - FRAC_BITS - 1))) >>> (TRIG_FRAC - FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c <= sat32(68'(w_cr));
            r_s <= sat32(68'(w_sr));
            r_r <= {1'b0, w_f.radius};
        end
    end

    // Stage B: c*c, s*c, r*r, b1c*c, b1c*s.
    t_word p_cc, p_sc, p_r2, p_bc, p_bs, r_rb, r_sb;
    fsg_qmul #(.FRAC_BITS(FRAC_BITS)) u_cc (i_clk, w_en, r_c, r_c, p_cc);
    fsg_qmul #(.FRAC_BITS(FRAC_BITS)) u_sc (i_clk, w_en, r_s, r_c, p_sc);
    fsg_qmul #(.FRAC_BITS(FRAC_BITS)) u_r2 (i_clk, w_en, r_r, r_r, p_r2);
    fsg_qmul #(.FRAC_BITS(FRAC_BITS)) u_bc (i_clk, w_en, r_b1c, r_c, p_bc);
    fsg_qmul #(.FRAC_BITS(FRAC_BITS)) u_bs (i_clk, w_en, r_b1c, r_s, p_bs);
    always_ff @(posedge i_clk) if (w_en) r_rb <= r_r;

    // Stage C: cos2, sin2.
    t_word r_cos2, r_sin2, r_rc, r_r2c, r_bcc, r_bsc;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cos2 <= sat32(68'sd2 * 68'(p_cc) - (68'sd1 <<< FRAC_BITS));
            r_sin2 <= sat32(68'sd2 * 68'(p_sc));
            r_rc <= r_rb;
            r_r2c <= p_r2;
            r_bcc <= p_bc;
            r_bsc <= p_bs;
        end
    end

    // Stage D: b2c*cos2, b2c*sin2, r*b1c_c, r*b1c_s.
    t_word p_bcos2, p_bsin2, p_rbc, p_rbs, r_rd, r_r2d, r_bcd;
    fsg_qmul #(.FRAC_BITS(FRAC_BITS)) u_bcos2 (i_clk, w_en, r_b2c, r_cos2, p_bcos2);
    fsg_qmul #(.FRAC_BITS(FRAC_BITS)) u_bsin2 (i_clk, w_en, r_b2c, r_sin2, p_bsin2);
    fsg_qmul #(.FRAC_BITS(FRAC_BITS)) u_rbc (i_clk, w_en, r_rc, r_bcc, p_rbc);
    fsg_qmul #(.FRAC_BITS(FRAC_BITS)) u_rbs (i_clk, w_en, r_rc, r_bsc, p_rbs);
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rd <= r_rc;
            r_r2d <= r_r2c;
            r_bcd <= r_bcc;
        end
    end

    // Stage E: inner.
    t_word r_inner, r_re, r_r2e, r_bce, r_rbce, r_rbse, r_bsin2e;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_inner <= sat32(68'(r_b20) + 68'(p_bcos2));
            r_re <= r_rd;
            r_r2e <= r_r2d;
            r_bce <= r_bcd;
            r_rbce <= p_rbc;
            r_rbse <= p_rbs;
            r_bsin2e <= p_bsin2;
        end
    end

    // Stage F: r2*inner, r*inner, r2*b2c_sin2.
    t_word p_r2i, p_ri, p_r2s, r_bcf, r_rbcf, r_rbsf;
    fsg_qmul #(.FRAC_BITS(FRAC_BITS)) u_r2i (i_clk, w_en, r_r2e, r_inner, p_r2i);
    fsg_qmul #(.FRAC_BITS(FRAC_BITS)) u_ri (i_clk, w_en, r_re, r_inner, p_ri);
    fsg_qmul #(.FRAC_BITS(FRAC_BITS)) u_r2s (i_clk, w_en, r_r2e, r_bsin2e, p_r2s);
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bcf <= r_bce;
            r_rbcf <= r_rbce;
            r_rbsf <= r_rbse;
        end
    end

    // Stage G: sums.
    t_word r_mag, r_dr, r_dth;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mag <= sat32(68'(r_b0) + 68'(r_rbcf) + 68'(p_r2i));
            r_dr <= sat32(68'(r_bcf) + 68'sd2 * 68'(p_ri));
            r_dth <= sat32(-(68'(r_rbsf) + 68'sd2 * 68'(p_r2s)));
        end
    end

    // Stage H: normalization.
    t_word p_mag, p_dr, p_dth;
    fsg_qmul #(.FRAC_BITS(FRAC_BITS)) u_nm (i_clk, w_en, r_mag, r_inv, p_mag);
    fsg_qmul #(.FRAC_BITS(FRAC_BITS)) u_nr (i_clk, w_en, r_dr, r_inv, p_dr);
    fsg_qmul #(.FRAC_BITS(FRAC_BITS)) u_nt (i_clk, w_en, r_dth, r_inv, p_dth);

    assign m_out.data.strength = p_mag;
    assign m_out.data.d_radius = p_dr;
    assign m_out.data.d_angle = p_dth;
endmodule

[rtl/fsg_cordic_cell.sv]
// One rotation cell of the CORDIC chain, registered.
// Uses fsg_pkg for the stage type and arctangent table.
`timescale 1ns / 1ps

module fsg_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  fsg_pkg::t_rot i_rot,
    output fsg_pkg::t_rot o_rot
);
    import fsg_pkg::*;

    t_rot r_rot;
    t_rot n_rot;

    always_comb begin
        n_rot = i_rot;
        if (!i_rot.z[33]) begin
            n_rot.x = i_rot.x - (i_rot.y >>> STEP);
            n_rot.y = i_rot.y + (i_rot.x >>> STEP);
            n_rot.z = i_rot.z - atan_q30(STEP);
        end else begin
            n_rot.x = i_rot.x + (i_rot.y >>> STEP);
            n_rot.y = i_rot.y - (i_rot.x >>> STEP);
            n_rot.z = i_rot.z + atan_q30(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
        end
    end

    assign o_rot = r_rot;
endmodule

[rtl/fsg_qmul.sv]
// Registered Q-format multiply with round half up and 32-bit saturation.
// Uses fsg_pkg for the saturation helper.
`timescale 1ns / 1ps

module fsg_qmul #(
    parameter int FRAC_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [31:0]  i_a,
    input  logic signed [31:0]  i_b,
    output logic signed [31:0]  o_p
);
    import fsg_pkg::*;

    logic signed [67:0] w_prod;
    logic signed [67:0] w_shift;
    logic signed [31:0] r_p;

    assign w_prod  = 68'(i_a) * 68'(i_b) + (68'sd1 <<< (FRAC_BITS - 1));
    assign w_shift = w_prod >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= sat32(w_shift);
        end
    end

    assign o_p = r_p;
endmodule

[rtl/fsg_checker.sv]
// Port-level checker for the field strength and gradient block, with its bind.
// Uses the assertion macros header.
`timescale 1ns / 1ps
`include "field_strength_and_gradient_assert.svh"

module fsg_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);
    `FSG_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)
    `FSG_ASSERT_IMPL(a_stall_blocks_in, i_clk, i_rst_n, i_out_valid && !i_out_ready, !i_in_ready)
    `FSG_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
endmodule

bind field_strength_and_gradient fsg_checker u_fsg_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_ready(s_in.ready),
    .i_out_valid(m_out.valid),
    .i_out_ready(m_out.ready)
);
